[hw/rtl/tbpd_pkg.sv]
// Shared types, register codes and constants for the twist/bend point deformer.
// Holds the CORDIC arctangent table and the fixed angle scale factors.
// No dependencies.
package tbpd_pkg;

   // Register map: index i at byte address 4*i
   localparam int CSR_ADDR_WIDTH = 3;

   typedef enum logic [0:0] {
      REG_MODE = 1'b0,
      REG_RATE = 1'b1
   } reg_index_type;

   typedef enum logic [0:0] {
      MODE_TWIST = 1'b0,
      MODE_BEND  = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [15:0] rate;
   } cfg_type;

   // 3.0 in Q4.12
   localparam logic signed [15:0] RATE_RESET = 16'sd12288;

   // round(2^32 / (2*pi)): Q28 radians to turns
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

   // CORDIC datapath widths: x/y in Q30, residual phase in 2^-32 turn
   localparam int TRIG_WIDTH  = 32;
   localparam int PHASE_WIDTH = 33;

   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         5'd24:   val = 32'd41;
         5'd25:   val = 32'd20;
         5'd26:   val = 32'd10;
         5'd27:   val = 32'd5;
         5'd28:   val = 32'd3;
         5'd29:   val = 32'd1;
         5'd30:   val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

[hw/rtl/tbpd_csr.sv]
// Configuration registers (mode, rate) behind an APB-style slave port.
// Depends on tbpd_pkg for the register codes and the config struct.
module tbpd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tbpd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output tbpd_pkg::cfg_type                   cfg
);

   tbpd_pkg::cfg_type       cfg_ff;
   tbpd_pkg::cfg_type       cfg_in;
   tbpd_pkg::reg_index_type idx;
   logic                    wr_en;

   // word-aligned decode: bit 2 picks the register
   assign idx        = tbpd_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // write path
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            tbpd_pkg::REG_MODE: cfg_in.mode = tbpd_pkg::mode_type'(csr_pwdata[0]);
            tbpd_pkg::REG_RATE: cfg_in.rate = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= tbpd_pkg::MODE_TWIST;
         cfg_ff.rate <= tbpd_pkg::RATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read path
   always_comb begin
      case (idx)
         tbpd_pkg::REG_MODE: csr_prdata = {31'd0, cfg_ff.mode};
         tbpd_pkg::REG_RATE: csr_prdata = {{16{cfg_ff.rate[15]}}, cfg_ff.rate};
         default:            csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/tbpd_angle.sv]
// Angle front end: rate*y, scale to turns, fold into [-1/4, 1/4) turn.
// Three register stages. Depends on tbpd_pkg for the turn scale factor.
module tbpd_angle #(
   parameter int COORD_WIDTH = 24,
   parameter int SIDE_WIDTH  = 72
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic signed [15:0]                       rate,
   input  logic signed [COORD_WIDTH-1:0]            py,
   input  logic [SIDE_WIDTH-1:0]                    side_in,
   output logic                                     out_valid,
   output logic signed [tbpd_pkg::PHASE_WIDTH-1:0]  phase,
   output logic                                     flip,
   output logic [SIDE_WIDTH-1:0]                    side_out
);

   localparam int PROD_WIDTH = COORD_WIDTH + 16;

   // stage 1: exact angle in Q28 radians
   logic                         v1_ff, v1_in;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic [SIDE_WIDTH-1:0]        side1_ff, side1_in;
   // stage 2: two 30-bit halves times the constant
   logic                         v2_ff, v2_in;
   logic [59:0]                  lo_ff, lo_in;
   logic [29:0]                  hi_ff, hi_in;
   logic [SIDE_WIDTH-1:0]        side2_ff, side2_in;
   // stage 3: phase fold
   logic                                    v3_ff, v3_in;
   logic signed [tbpd_pkg::PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic                                    flip_ff, flip_in;
   logic [SIDE_WIDTH-1:0]                   side3_ff, side3_in;

   logic [63:0] prod_ext;
   logic [59:0] hi_full;
   logic [59:0] turn_sum;
   logic [31:0] turn;

   // only bits 0..59 of the angle reach bits 28..59 of the scaled product
   assign prod_ext = 64'(prod_ff);
   assign hi_full  = prod_ext[59:30] * tbpd_pkg::INV_TWO_PI_Q32;
   assign turn_sum = lo_ff + {hi_ff, 30'd0};
   assign turn     = turn_sum[59:28];

   always_comb begin
      v1_in    = in_valid;
      prod_in  = rate * py;
      side1_in = side_in;

      v2_in    = v1_ff;
      lo_in    = prod_ext[29:0] * tbpd_pkg::INV_TWO_PI_Q32;
      hi_in    = hi_full[29:0];
      side2_in = side1_ff;

      // second or third quarter turn: add half a turn, negate cos/sin later
      v3_in    = v2_ff;
      flip_in  = turn[31] ^ turn[30];
      phase_in = tbpd_pkg::PHASE_WIDTH'($signed({turn[31] ^ flip_in, turn[30:0]}));
      side3_in = side2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         side1_ff <= side1_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         side2_ff <= side2_in;
         phase_ff <= phase_in;
         flip_ff  <= flip_in;
         side3_ff <= side3_in;
      end
   end

   assign out_valid = v3_ff;
   assign phase     = phase_ff;
   assign flip      = flip_ff;
   assign side_out  = side3_ff;

endmodule

[hw/rtl/tbpd_cordic.sv]
// Rotation-mode CORDIC, one registered micro-rotation per stage.
// Depends on tbpd_pkg for the gain, widths and arctangent table.
module tbpd_cordic #(
   parameter int ROTATION_STAGES = 18,
   parameter int SIDE_WIDTH      = 72
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic signed [tbpd_pkg::PHASE_WIDTH-1:0] phase,
   input  logic                                    flip_in,
   input  logic [SIDE_WIDTH-1:0]                   side_in,
   output logic                                    out_valid,
   output logic signed [tbpd_pkg::TRIG_WIDTH-1:0]  cos_q30,
   output logic signed [tbpd_pkg::TRIG_WIDTH-1:0]  sin_q30,
   output logic                                    flip_out,
   output logic [SIDE_WIDTH-1:0]                   side_out
);

   localparam int TW = tbpd_pkg::TRIG_WIDTH;
   localparam int ZW = tbpd_pkg::PHASE_WIDTH;
   localparam int N  = ROTATION_STAGES;

   logic                  v_ff    [N];
   logic                  v_in    [N];
   logic signed [TW-1:0]  x_ff    [N];
   logic signed [TW-1:0]  x_in    [N];
   logic signed [TW-1:0]  y_ff    [N];
   logic signed [TW-1:0]  y_in    [N];
   logic signed [ZW-1:0]  z_ff    [N];
   logic signed [ZW-1:0]  z_in    [N];
   logic                  f_ff    [N];
   logic                  f_in    [N];
   logic [SIDE_WIDTH-1:0] side_ff [N];
   logic [SIDE_WIDTH-1:0] side_in_q [N];

   logic                  v_src    [N];
   logic signed [TW-1:0]  x_src    [N];
   logic signed [TW-1:0]  y_src    [N];
   logic signed [ZW-1:0]  z_src    [N];
   logic                  f_src    [N];
   logic [SIDE_WIDTH-1:0] side_src [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [ZW-1:0] ATAN =
         ZW'($signed({1'b0, tbpd_pkg::atan_turn(5'(i))}));

      // stage source: the front end for the first, else the stage before
      if (i == 0) begin : g_first
         assign v_src[i]    = in_valid;
         assign x_src[i]    = tbpd_pkg::CORDIC_GAIN_Q30;
         assign y_src[i]    = '0;
         assign z_src[i]    = phase;
         assign f_src[i]    = flip_in;
         assign side_src[i] = side_in;
      end else begin : g_next
         assign v_src[i]    = v_ff[i-1];
         assign x_src[i]    = x_ff[i-1];
         assign y_src[i]    = y_ff[i-1];
         assign z_src[i]    = z_ff[i-1];
         assign f_src[i]    = f_ff[i-1];
         assign side_src[i] = side_ff[i-1];
      end

      // micro-rotation toward zero residual phase
      always_comb begin
         v_in[i]      = v_src[i];
         f_in[i]      = f_src[i];
         side_in_q[i] = side_src[i];
         if (z_src[i] >= 0) begin
            x_in[i] = x_src[i] - (y_src[i] >>> i);
            y_in[i] = y_src[i] + (x_src[i] >>> i);
            z_in[i] = z_src[i] - ATAN;
         end else begin
            x_in[i] = x_src[i] + (y_src[i] >>> i);
            y_in[i] = y_src[i] - (x_src[i] >>> i);
            z_in[i] = z_src[i] + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            f_ff[i]    <= f_in[i];
            side_ff[i] <= side_in_q[i];
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign cos_q30   = x_ff[N-1];
   assign sin_q30   = y_ff[N-1];
   assign flip_out  = f_ff[N-1];
   assign side_out  = side_ff[N-1];

   // residual phase after the last stage must have converged
   localparam int ZBOUND_I =
      2 * int'(tbpd_pkg::atan_turn(5'(N - 1))) + 256;
   localparam logic signed [ZW-1:0] ZBOUND = ZW'(ZBOUND_I);

   a_residual_small : assert property (@(posedge clock) disable iff (reset)
      v_ff[N-1] |-> (z_ff[N-1] <= ZBOUND) && (z_ff[N-1] >= -ZBOUND))
      else $error("CORDIC residual phase did not converge");

endmodule

[hw/rtl/tbpd_rotate.sv]
// Output rotation: sign fix and rounding of cos/sin, split products,
// product sums, then round, shift and saturate. Four register stages.
// Depends on tbpd_pkg for the trig width.
module tbpd_rotate #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [tbpd_pkg::TRIG_WIDTH-1:0] cos_q30,
   input  logic signed [tbpd_pkg::TRIG_WIDTH-1:0] sin_q30,
   input  logic                                   flip,
   input  logic [3*COORD_WIDTH-1:0]               side_in,
   output logic                                   out_valid,
   output logic [COORD_WIDTH-1:0]                 qx,
   output logic [COORD_WIDTH-1:0]                 qy,
   output logic [COORD_WIDTH-1:0]                 qz
);

   localparam int CW        = COORD_WIDTH;
   localparam int TW        = tbpd_pkg::TRIG_WIDTH;
   localparam int TRIG_FRAC = (CW <= 32) ? 30 : 62 - CW;
   localparam int DROP      = 30 - TRIG_FRAC;
   localparam int HALF_I    = (DROP == 0) ? 0 : (1 << ((DROP > 0) ? DROP - 1 : 0));
   localparam int HP_WIDTH  = CW + 16;
   localparam int LP_WIDTH  = CW + 17;
   localparam int PP_WIDTH  = CW + TW;
   localparam int SW        = CW + TW + 2;

   localparam logic signed [TW+1:0] HALF = (TW + 2)'(HALF_I);
   localparam logic signed [SW-1:0] RND  =
      $signed({{(SW - TRIG_FRAC){1'b0}}, 1'b1, {(TRIG_FRAC - 1){1'b0}}});
   localparam logic signed [SW-1:0] MAXV =
      $signed({{(SW - CW + 1){1'b0}}, {(CW - 1){1'b1}}});
   localparam logic signed [SW-1:0] MINV =
      $signed({{(SW - CW + 1){1'b1}}, {(CW - 1){1'b0}}});

   // stage 1: cos/sin with sign and rounding applied
   logic                       v1_ff, v1_in;
   logic signed [TW-1:0]       c_ff, c_in, s_ff, s_in;
   logic [3*CW-1:0]            side1_ff, side1_in;
   // stage 2: partial products, high signed half and low unsigned half
   logic                       v2_ff, v2_in;
   logic signed [HP_WIDTH-1:0] xch_ff, xch_in, bsh_ff, bsh_in;
   logic signed [HP_WIDTH-1:0] xsh_ff, xsh_in, bch_ff, bch_in;
   logic signed [LP_WIDTH-1:0] xcl_ff, xcl_in, bsl_ff, bsl_in;
   logic signed [LP_WIDTH-1:0] xsl_ff, xsl_in, bcl_ff, bcl_in;
   logic [CW-1:0]              keep2_ff, keep2_in;
   // stage 3: full products
   logic                       v3_ff, v3_in;
   logic signed [PP_WIDTH-1:0] xc_ff, xc_in, bs_ff, bs_in, xs_ff, xs_in, bc_ff, bc_in;
   logic [CW-1:0]              keep3_ff, keep3_in;
   // stage 4: results
   logic                       v4_ff, v4_in;
   logic [CW-1:0]              qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;

   logic signed [TW+1:0]   c_signed, s_signed;
   logic signed [TW+1:0]   c_round, s_round;
   logic signed [CW-1:0]   px_s, pb_s;
   logic signed [15:0]     c_hi, s_hi;
   logic signed [16:0]     c_lo, s_lo;
   logic signed [SW-1:0]   rx_sum, ry_sum, rx_sh, ry_sh;

   // stage 1 datapath
   assign c_signed = flip ? -(TW + 2)'(cos_q30) : (TW + 2)'(cos_q30);
   assign s_signed = flip ? -(TW + 2)'(sin_q30) : (TW + 2)'(sin_q30);
   assign c_round  = (c_signed + HALF) >>> DROP;
   assign s_round  = (s_signed + HALF) >>> DROP;

   // stage 2 datapath: side word is {keep, b, x}
   assign px_s = $signed(side1_ff[CW-1:0]);
   assign pb_s = $signed(side1_ff[2*CW-1:CW]);
   assign c_hi = c_ff[TW-1:16];
   assign s_hi = s_ff[TW-1:16];
   assign c_lo = $signed({1'b0, c_ff[15:0]});
   assign s_lo = $signed({1'b0, s_ff[15:0]});

   // stage 4 datapath
   assign rx_sum = SW'(xc_ff) - SW'(bs_ff) + RND;
   assign ry_sum = SW'(xs_ff) + SW'(bc_ff) + RND;
   assign rx_sh  = rx_sum >>> TRIG_FRAC;
   assign ry_sh  = ry_sum >>> TRIG_FRAC;

   always_comb begin
      v1_in    = in_valid;
      c_in     = TW'(c_round);
      s_in     = TW'(s_round);
      side1_in = side_in;

      v2_in    = v1_ff;
      xch_in   = px_s * c_hi;
      bsh_in   = pb_s * s_hi;
      xsh_in   = px_s * s_hi;
      bch_in   = pb_s * c_hi;
      xcl_in   = px_s * c_lo;
      bsl_in   = pb_s * s_lo;
      xsl_in   = px_s * s_lo;
      bcl_in   = pb_s * c_lo;
      keep2_in = side1_ff[3*CW-1:2*CW];

      v3_in    = v2_ff;
      xc_in    = (PP_WIDTH'(xch_ff) <<< 16) + PP_WIDTH'(xcl_ff);
      bs_in    = (PP_WIDTH'(bsh_ff) <<< 16) + PP_WIDTH'(bsl_ff);
      xs_in    = (PP_WIDTH'(xsh_ff) <<< 16) + PP_WIDTH'(xsl_ff);
      bc_in    = (PP_WIDTH'(bch_ff) <<< 16) + PP_WIDTH'(bcl_ff);
      keep3_in = keep2_ff;

      // saturate to the coordinate range
      v4_in = v3_ff;
      if (rx_sh > MAXV) begin
         qx_in = MAXV[CW-1:0];
      end else if (rx_sh < MINV) begin
         qx_in = MINV[CW-1:0];
      end else begin
         qx_in = rx_sh[CW-1:0];
      end
      if (ry_sh > MAXV) begin
         qy_in = MAXV[CW-1:0];
      end else if (ry_sh < MINV) begin
         qy_in = MINV[CW-1:0];
      end else begin
         qy_in = ry_sh[CW-1:0];
      end
      qz_in = keep3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff     <= c_in;
         s_ff     <= s_in;
         side1_ff <= side1_in;
         xch_ff   <= xch_in;
         bsh_ff   <= bsh_in;
         xsh_ff   <= xsh_in;
         bch_ff   <= bch_in;
         xcl_ff   <= xcl_in;
         bsl_ff   <= bsl_in;
         xsl_ff   <= xsl_in;
         bcl_ff   <= bcl_in;
         keep2_ff <= keep2_in;
         xc_ff    <= xc_in;
         bs_ff    <= bs_in;
         xs_ff    <= xs_in;
         bc_ff    <= bc_in;
         keep3_ff <= keep3_in;
         qx_ff    <= qx_in;
         qy_ff    <= qy_in;
         qz_ff    <= qz_in;
      end
   end

   assign out_valid = v4_ff;
   assign qx        = qx_ff;
   assign qy        = qy_ff;
   assign qz        = qz_ff;

endmodule

[hw/rtl/twist_bend_point_deform.sv]
// Twist / bend point deformer for implicit-surface evaluation.
// Channels: req_* takes one point word {pz, py, px}; rsp_* gives one
// deformed point word {qz, qy, qx}; csr_* is the APB register port
// (mode at 0x0: 0 twist, 1 bend; rate at 0x4: signed Q4.12 angle per unit y).
// Twist rotates (x,z) by rate*y and returns (x', z', y); bend rotates (x,y)
// and returns (x', y', z). Rotated values are rounded and saturated.
// Pipeline from accept to rsp_tvalid: three angle stages, one stage per
// CORDIC micro-rotation, four output rotation stages.
// Throughput: one point per cycle while the skid register is empty; every
// stage is a register with a valid bit and the whole pipe advances together.
// Stall: a word the receiver does not take moves into a skid register;
// the pipe then holds and req_tready drops until that word is taken.
// req_tready depends on registered state only.
// Reset: clears all valid bits and the skid register, mode returns to
// twist and rate to 3.0. Change registers only while the block is empty.
// Depends on tbpd_pkg, tbpd_csr, tbpd_angle, tbpd_cordic, tbpd_rotate.
module twist_bend_point_deform #(
   parameter int COORD_WIDTH     = 24,
   parameter int ROTATION_STAGES = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   // px [CW-1:0], py [2CW-1:CW], pz [3CW-1:2CW], zero padded to bytes
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // qx [CW-1:0], qy [2CW-1:CW], qz [3CW-1:2CW], zero padded to bytes
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tbpd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam int CW      = COORD_WIDTH;
   localparam int TDATA_W = ((3 * CW + 7) / 8) * 8;
   localparam int SIDE_W  = 3 * CW;
   localparam int DEPTH   = ROTATION_STAGES + 8;
   localparam int CNT_W   = $clog2(DEPTH + 1);

   tbpd_pkg::cfg_type cfg;

   logic                   pipe_en;
   logic signed [CW-1:0]   px, py, pz;
   logic [CW-1:0]          b_sel, keep_sel;
   logic [SIDE_W-1:0]      side_entry;

   logic                                    ang_valid;
   logic signed [tbpd_pkg::PHASE_WIDTH-1:0] ang_phase;
   logic                                    ang_flip;
   logic [SIDE_W-1:0]                       ang_side;

   logic                                   cor_valid;
   logic signed [tbpd_pkg::TRIG_WIDTH-1:0] cor_cos, cor_sin;
   logic                                   cor_flip;
   logic [SIDE_W-1:0]                      cor_side;

   logic                  last_valid;
   logic [CW-1:0]         last_qx, last_qy, last_qz;
   logic [SIDE_W-1:0]     last_word;

   logic                  skid_valid_ff, skid_valid_in;
   logic [SIDE_W-1:0]     skid_word_ff, skid_word_in;

   logic                  accept, deliver;
   logic [CNT_W-1:0]      count_ff, count_in;

   tbpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // entry: pick the coordinate rotated with x and the one passed through
   assign px = $signed(req_tdata[CW-1:0]);
   assign py = $signed(req_tdata[2*CW-1:CW]);
   assign pz = $signed(req_tdata[3*CW-1:2*CW]);

   always_comb begin
      case (cfg.mode)
         tbpd_pkg::MODE_BEND: begin
            b_sel    = py;
            keep_sel = pz;
         end
         tbpd_pkg::MODE_TWIST: begin
            b_sel    = pz;
            keep_sel = py;
         end
         default: begin
            b_sel    = pz;
            keep_sel = py;
         end
      endcase
   end

   assign side_entry = {keep_sel, b_sel, px};

   // the whole pipe moves unless the skid register is occupied
   assign pipe_en    = !skid_valid_ff;
   assign req_tready = pipe_en;

   tbpd_angle #(
      .COORD_WIDTH (CW),
      .SIDE_WIDTH  (SIDE_W)
   ) u_angle (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_tvalid),
      .rate      (cfg.rate),
      .py        (py),
      .side_in   (side_entry),
      .out_valid (ang_valid),
      .phase     (ang_phase),
      .flip      (ang_flip),
      .side_out  (ang_side)
   );

   tbpd_cordic #(
      .ROTATION_STAGES (ROTATION_STAGES),
      .SIDE_WIDTH      (SIDE_W)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (ang_valid),
      .phase     (ang_phase),
      .flip_in   (ang_flip),
      .side_in   (ang_side),
      .out_valid (cor_valid),
      .cos_q30   (cor_cos),
      .sin_q30   (cor_sin),
      .flip_out  (cor_flip),
      .side_out  (cor_side)
   );

   tbpd_rotate #(
      .COORD_WIDTH (CW)
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (cor_valid),
      .cos_q30   (cor_cos),
      .sin_q30   (cor_sin),
      .flip      (cor_flip),
      .side_in   (cor_side),
      .out_valid (last_valid),
      .qx        (last_qx),
      .qy        (last_qy),
      .qz        (last_qz)
   );

   assign last_word = {last_qz, last_qy, last_qx};

   // skid register: catches the last stage's word when the receiver stalls
   always_comb begin
      skid_word_in = skid_word_ff;
      if (skid_valid_ff) begin
         skid_valid_in = !rsp_tready;
      end else begin
         skid_valid_in = last_valid && !rsp_tready;
         skid_word_in  = last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      skid_word_ff <= skid_word_in;
   end

   assign rsp_tvalid = skid_valid_ff || last_valid;
   assign rsp_tdata  = skid_valid_ff ? TDATA_W'(skid_word_ff) : TDATA_W'(last_word);

   // words in flight, for checking
   assign accept  = req_tvalid && req_tready;
   assign deliver = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff;
      if (accept && !deliver) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deliver && !accept) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_depth_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("more words in flight than pipeline stages");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count_ff != '0)
      else $error("result presented with no word in flight");

   a_full_holds : assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'(DEPTH) |-> !req_tready)
      else $error("input accepted while every stage is occupied");

endmodule
